// ===== design/arp_cache_aging_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Clocked assertion helpers used by the ARP cache unit.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_AGING_TABLE_UNIT_MACROS_SVH
`define ARP_CACHE_AGING_TABLE_UNIT_MACROS_SVH

// check a property at every clock edge outside reset
`define ARPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check a property at every clock edge, reset included
`define ARPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== design/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP cache package
// Transaction payload types, table entry layout, codes and sequencer states.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;
   localparam int AGE_W  = 16;
   localparam int SLOT_W = 7;
   localparam int MODE_W = 2;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

   localparam logic [AGE_W-1:0] AGE_MAX       = 16'hFFFF;
   localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd15;

   localparam int            CSR_ADDR_W      = 3;
   localparam int            CSR_DATA_W      = 32;
   localparam logic          CSR_IDX_TIMEOUT = 1'b0;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IP_W-1:0]   ip_addr;
      logic [MAC_W-1:0]  mac_addr;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [MAC_W-1:0]  mac_found;
      logic              stored;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
      logic [AGE_W-1:0] age;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ===== design/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// ARP cache RAM
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module arpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/arp_cache_aging_table_unit.sv =====
// ----------------------------------------------------------------------------
// ARP cache with aging
// Table of IPv4 to MAC mappings with per-entry age, scanned by one sequencer.
// ----------------------------------------------------------------------------
// Every transaction (lookup, insert or tick) walks the table through the
// single read port of the entry RAM, one entry per cycle. A lookup or a tick
// keeps busy high until the last entry has been evaluated and shows its result
// in the first cycle with busy low. An insert ends early at the first free
// slot. A new start is taken in the cycle of the strobe. After reset a
// clearing pass marks every entry invalid while busy is high. The result is
// shown for exactly one cycle under rsp_strobe and cannot be held off.
`include "arp_cache_aging_table_unit_macros.svh"

module arp_cache_aging_table_unit #(
   parameter int ENTRIES = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  arpc_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output arpc_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [arpc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [arpc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import arpc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] ENTRY_CNT  = CNT_W'(ENTRIES);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [AGE_W-1:0]  timeout_ff;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   entry_type         ram_rd_data;

   logic [AGE_W-1:0]  age_next;
   logic              csr_write;

   arpc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // configuration registers
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_IDX_TIMEOUT) ? CSR_DATA_W'(timeout_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write && (paddr[2] == CSR_IDX_TIMEOUT)) begin
         timeout_ff <= pwdata[AGE_W-1:0];
      end
   end

   assign age_next = (ram_rd_data.age == AGE_MAX) ? AGE_MAX : ram_rd_data.age + 1'b1;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         rd_cnt_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         rd_cnt_ff     <= rd_cnt_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
   end

   always_comb begin
      logic finish;
      finish        = 1'b0;
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      rd_cnt_in     = rd_cnt_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      rsp_strobe_in = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pend_idx_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_cnt_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_ff;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               res_in    = '0;
               rd_cnt_in = '0;
               pend_in   = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue the next read while the previous entry is evaluated
            ram_rd_en   = rd_cnt_ff < ENTRY_CNT;
            pend_in     = ram_rd_en;
            pend_idx_in = rd_cnt_ff[IDX_W-1:0];
            if (ram_rd_en) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               unique case (req_ff.mode)
                  MODE_LOOKUP: begin
                     if (ram_rd_data.valid && (ram_rd_data.ip == req_ff.ip_addr)) begin
                        res_in.hit       = 1'b1;
                        res_in.mac_found = ram_rd_data.mac;
                        res_in.slot      = SLOT_W'(pend_idx_ff);
                     end
                  end
                  MODE_INSERT: begin
                     if (!ram_rd_data.valid) begin
                        ram_wr_en         = 1'b1;
                        ram_wr_data.valid = 1'b1;
                        ram_wr_data.ip    = req_ff.ip_addr;
                        ram_wr_data.mac   = req_ff.mac_addr;
                        ram_wr_data.age   = '0;
                        res_in.stored     = 1'b1;
                        res_in.slot       = SLOT_W'(pend_idx_ff);
                        finish            = 1'b1;
                     end
                  end
                  MODE_TICK: begin
                     if (ram_rd_data.valid) begin
                        ram_wr_en         = 1'b1;
                        ram_wr_data       = ram_rd_data;
                        ram_wr_data.age   = age_next;
                        ram_wr_data.valid = !(age_next > timeout_ff);
                     end
                  end
                  default: begin
                  end
               endcase
               if (pend_idx_ff == LAST_IDX) begin
                  finish = 1'b1;
               end
            end
            if (finish) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = res_ff;

   `ARPC_ASSERT(a_strobe_after_scan, rsp_strobe_ff |-> ($past(state_ff) == ST_SCAN), "result strobe without a scan")
   `ARPC_ASSERT(a_idle_no_write, (state_ff == ST_IDLE) |-> !ram_wr_en, "entry write while idle")
   `ARPC_ASSERT(a_port_conflict, (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr), "read and write hit one entry")
   `ARPC_ASSERT(a_start_scan, (start && !busy) |=> ((state_ff == ST_SCAN) && !pend_ff), "accepted transaction did not start a scan")
   `ARPC_ASSERT(a_hit_xor_stored, rsp_strobe_ff |-> !(rsp_data.hit && rsp_data.stored), "hit and stored both set")
   `ARPC_ASSERT_ALWAYS(a_reset_clears, reset |=> (state_ff == ST_CLEAR), "reset did not start the clearing pass")

endmodule
